### rtl/core/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg: shared types and codes for the positional deque
// Request and response payloads, action and status codes, and the control
// bundle passed from the decoder to the cell row.
// ----------------------------------------------------------------------------
package pdq_pkg;

   // action codes
   localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
   localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
   localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
   localparam logic [2:0] ACT_POP_BACK   = 3'd3;
   localparam logic [2:0] ACT_INSERT     = 3'd4;
   localparam logic [2:0] ACT_ERASE      = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // cell row operations
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_OPEN  = 2'd1;
   localparam logic [1:0] KIND_CLOSE = 2'd2;
   localparam logic [1:0] KIND_DROP  = 2'd3;

   // gap index carried wide enough for the largest supported depth (256)
   localparam int GAP_W = 8;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] item_value;
      logic [3:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
      logic [4:0]         entry_count;
      logic               is_empty;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [GAP_W-1:0]   gap;
      logic signed [31:0] value;
      logic [1:0]         status;
   } ctrl_type;

endpackage

### rtl/core/pdq_ctrl.sv
// ----------------------------------------------------------------------------
// pdq_ctrl: action decode and bounds checks
// Turns the registered request and the current fill count into a cell row
// operation, a status code and the next fill count.
// ----------------------------------------------------------------------------
module pdq_ctrl #(
   parameter int DEPTH = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic            req_valid,
   input  pdq_pkg::req_type req,
   input  logic [CW-1:0]   count_ff,
   output pdq_pkg::ctrl_type ctrl,
   output logic [CW-1:0]   count_in
);
   import pdq_pkg::*;

   localparam int CMP_W = ((CW > 4) ? CW : 4) + 1;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] count_ext;
   logic             full;
   logic             empty;
   logic             pos_in_range;

   assign pos_ext      = CMP_W'(req.position);
   assign count_ext    = CMP_W'(count_ff);
   assign full         = (count_ff == CW'(DEPTH));
   assign empty        = (count_ff == '0);
   assign pos_in_range = (pos_ext < count_ext);

   // decode one transfer
   always_comb begin
      ctrl.kind   = KIND_NONE;
      ctrl.gap    = '0;
      ctrl.value  = req.item_value;
      ctrl.status = ST_OK;
      count_in    = count_ff;
      if (req_valid) begin
         unique case (req.action)
            ACT_PUSH_FRONT: begin
               if (full) begin
                  ctrl.status = ST_FULL;
               end else begin
                  ctrl.kind = KIND_OPEN;
                  count_in  = count_ff + CW'(1);
               end
            end
            ACT_PUSH_BACK: begin
               if (full) begin
                  ctrl.status = ST_FULL;
               end else begin
                  ctrl.kind = KIND_OPEN;
                  ctrl.gap  = GAP_W'(count_ext);
                  count_in  = count_ff + CW'(1);
               end
            end
            ACT_POP_FRONT: begin
               if (empty) begin
                  ctrl.status = ST_EMPTY;
               end else begin
                  ctrl.kind = KIND_CLOSE;
                  count_in  = count_ff - CW'(1);
               end
            end
            ACT_POP_BACK: begin
               if (empty) begin
                  ctrl.status = ST_EMPTY;
               end else begin
                  ctrl.kind = KIND_DROP;
                  count_in  = count_ff - CW'(1);
               end
            end
            ACT_INSERT: begin
               // position zero is always legal; bad position beats full
               if (pos_ext != '0 && !pos_in_range) begin
                  ctrl.status = ST_BADPOS;
               end else if (full) begin
                  ctrl.status = ST_FULL;
               end else begin
                  ctrl.kind = KIND_OPEN;
                  ctrl.gap  = GAP_W'(pos_ext);
                  count_in  = count_ff + CW'(1);
               end
            end
            ACT_ERASE: begin
               if (!pos_in_range) begin
                  ctrl.status = ST_BADPOS;
               end else begin
                  ctrl.kind = KIND_CLOSE;
                  ctrl.gap  = GAP_W'(pos_ext);
                  count_in  = count_ff - CW'(1);
               end
            end
            default: begin
               // undefined actions leave everything alone
               ctrl.kind = KIND_NONE;
            end
         endcase
      end
   end

endmodule

### rtl/core/pdq_cells.sv
// ----------------------------------------------------------------------------
// pdq_cells: row of storage cells
// Every cell picks its next word from itself, a neighbour or the new word,
// so inserts and erases move the whole tail together.
// ----------------------------------------------------------------------------
module pdq_cells #(
   parameter int DEPTH = 16,
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  pdq_pkg::ctrl_type ctrl,
   input  logic [CW-1:0]     count_in,
   output logic signed [31:0] front_in,
   output logic signed [31:0] back_in
);
   import pdq_pkg::*;

   localparam int IW = $clog2(DEPTH);

   logic signed [31:0] cell_ff [DEPTH];
   logic signed [31:0] cell_in [DEPTH];
   logic [IW-1:0]      gap;
   logic [CW-1:0]      back_pos;

   assign gap = ctrl.gap[IW-1:0];

   // per-cell next value
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [31:0] prev_w;
      logic signed [31:0] next_w;

      if (i == 0) begin : g_first
         assign prev_w = cell_ff[i];
      end else begin : g_prev
         assign prev_w = cell_ff[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign next_w = cell_ff[i];
      end else begin : g_next
         assign next_w = cell_ff[i+1];
      end

      always_comb begin
         cell_in[i] = cell_ff[i];
         unique case (ctrl.kind)
            KIND_OPEN: begin
               if (IW'(i) == gap) begin
                  cell_in[i] = ctrl.value;
               end else if (IW'(i) > gap) begin
                  cell_in[i] = prev_w;
               end
            end
            KIND_CLOSE: begin
               if (IW'(i) >= gap) begin
                  cell_in[i] = next_w;
               end
            end
            KIND_NONE, KIND_DROP: begin
               cell_in[i] = cell_ff[i];
            end
         endcase
      end
   end

   // storage, no reset: entries are written before they are read
   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   // front and back after this transfer
   assign back_pos = count_in - CW'(1);

   always_comb begin
      if (count_in == '0) begin
         front_in = '0;
         back_in  = '0;
      end else begin
         front_in = cell_in[0];
         back_in  = cell_in[back_pos[IW-1:0]];
      end
   end

endmodule

### rtl/core/positional_deque.sv
// ----------------------------------------------------------------------------
// positional_deque: bounded deque with positional insert and erase
// A taken request passes the request register, then the cell update and
// result register, before its response strobe rises.
// Throughput: one request per cycle while busy is low; busy is high in reset and until the first edge after it.
// Reset clears the fill count and the strobes; cell contents are left as is.
// Results cannot be stalled; each response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module positional_deque #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  pdq_pkg::req_type req_data,
   output logic             rsp_strobe,
   output pdq_pkg::rsp_type rsp_data
);
   import pdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic          busy_ff;
   logic          req_valid_ff;
   req_type       req_ff;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   ctrl_type      ctrl;
   logic signed [31:0] front_in;
   logic signed [31:0] back_in;
   logic [CW+4:0] count_wide;
   logic          rsp_strobe_ff;
   rsp_type       rsp_data_ff;
   rsp_type       rsp_data_in;

   assign busy = busy_ff;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= start && !busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_ff <= req_data;
      end
   end

   // decode and bounds checks
   pdq_ctrl #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_ctrl (
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .count_ff  (count_ff),
      .ctrl      (ctrl),
      .count_in  (count_in)
   );

   // cell row
   pdq_cells #(
      .DEPTH (DEPTH),
      .CW    (CW)
   ) u_cells (
      .clock    (clock),
      .ctrl     (ctrl),
      .count_in (count_in),
      .front_in (front_in),
      .back_in  (back_in)
   );

   // fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // result register
   assign count_wide = {5'b0, count_in};

   always_comb begin
      rsp_data_in.front_value = front_in;
      rsp_data_in.back_value  = back_in;
      rsp_data_in.entry_count = count_wide[4:0];
      rsp_data_in.is_empty    = (count_in == '0);
      rsp_data_in.status      = ctrl.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fill count above depth");

   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_strobe)
      else $error("accepted transfer gave no response");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (req_valid_ff && ctrl.status == ST_FULL) |=> (count_ff == CW'(DEPTH)))
      else $error("refused push changed the fill count");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (count_ff == '0)))
      else $error("empty flag disagrees with fill count");

endmodule

### verif/positional_deque_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_deque_checker: response predictor and scoreboard
// Watches the request and response channels of the deque, keeps a shadow
// copy of the stored words, forecasts the response of every request taken
// and compares each strobed response field by field with the oldest forecast.
// ----------------------------------------------------------------------------
module positional_deque_checker #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  pdq_pkg::req_type req_data,
   input  logic             rsp_strobe,
   input  pdq_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               open_count,
   output int               checked_count,
   output int               badpos_count,
   output int               popempty_count,
   output int               full_count
);
   import pdq_pkg::*;

   // shadow of the stored sequence, front at index 0
   logic signed [31:0] words [0:DEPTH-1];
   int                 word_count;

   // forecast responses, oldest first
   rsp_type due_rsp [$];

   initial begin
      error_count    = 0;
      checked_count  = 0;
      badpos_count   = 0;
      popempty_count = 0;
      full_count     = 0;
      open_count     = 0;
      word_count     = 0;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      error_count++;
   endtask

   // open a slot at p, everything from p onwards moves one place back
   function automatic void make_room(input int p, input logic signed [31:0] v);
      int i;
      for (i = word_count; i > p; i--)
         words[i] = words[i-1];
      words[p] = v;
      word_count++;
   endfunction

   // drop the word at p, everything behind it moves one place forward
   function automatic void squeeze_out(input int p);
      int i;
      for (i = p; i + 1 < word_count; i++)
         words[i] = words[i+1];
      word_count--;
   endfunction

   // carry out one request on the shadow and forecast its response
   function automatic rsp_type apply_action(input req_type rq);
      rsp_type    r;
      logic [1:0] st;
      int         p;
      bit         full;
      st   = ST_OK;
      p    = rq.position;
      full = (word_count >= DEPTH);
      case (rq.action)
         ACT_PUSH_FRONT: begin
            if (full) st = ST_FULL;
            else make_room(0, rq.item_value);
         end
         ACT_PUSH_BACK: begin
            if (full) st = ST_FULL;
            else make_room(word_count, rq.item_value);
         end
         ACT_POP_FRONT: begin
            if (word_count == 0) st = ST_EMPTY;
            else squeeze_out(0);
         end
         ACT_POP_BACK: begin
            if (word_count == 0) st = ST_EMPTY;
            else word_count--;
         end
         ACT_INSERT: begin
            // position is checked ahead of fill
            if (p != 0 && p >= word_count) st = ST_BADPOS;
            else if (full) st = ST_FULL;
            else make_room(p, rq.item_value);
         end
         ACT_ERASE: begin
            if (p >= word_count) st = ST_BADPOS;
            else squeeze_out(p);
         end
         default: ;   // unused codes leave everything alone
      endcase
      r.front_value = (word_count == 0) ? '0 : words[0];
      r.back_value  = (word_count == 0) ? '0 : words[word_count-1];
      r.entry_count = word_count[4:0];
      r.is_empty    = (word_count == 0);
      r.status      = st;
      return r;
   endfunction

   // compare responses first, then log the request taken at this edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         due_rsp.delete();
         word_count = 0;
         open_count <= 0;
      end else begin
         if (rsp_strobe) begin
            if (due_rsp.size() == 0) begin
               report_mismatch("response strobe with no request outstanding");
            end else begin
               want = due_rsp[0];
               due_rsp.delete(0);
               checked_count++;
               if (rsp_data.front_value !== want.front_value)
                  report_mismatch($sformatf("front_value got %0d want %0d",
                                            rsp_data.front_value, want.front_value));
               if (rsp_data.back_value !== want.back_value)
                  report_mismatch($sformatf("back_value got %0d want %0d",
                                            rsp_data.back_value, want.back_value));
               if (rsp_data.entry_count !== want.entry_count)
                  report_mismatch($sformatf("entry_count got %0d want %0d",
                                            rsp_data.entry_count, want.entry_count));
               if (rsp_data.is_empty !== want.is_empty)
                  report_mismatch($sformatf("is_empty got %b want %b",
                                            rsp_data.is_empty, want.is_empty));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d",
                                            rsp_data.status, want.status));
               case (want.status)
                  ST_BADPOS: badpos_count++;
                  ST_EMPTY:  popempty_count++;
                  ST_FULL:   full_count++;
                  default: ;
               endcase
            end
         end
         // request transfer
         if (start && !busy)
            due_rsp.insert(due_rsp.size(), apply_action(req_data));
         open_count <= due_rsp.size();
      end
   end

endmodule

### verif/positional_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_deque_tb: top level of the deque testbench
// Drives a directed run over the corner cases (empty pops and erases, bad
// positions, extreme words, unused action codes) and then phases of random
// requests biased to fill, to drain or to mix, with random idle gaps and
// back-to-back bursts. The checker beside the block scores every response.
// ----------------------------------------------------------------------------
module positional_deque_tb;
   import pdq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RANDOM_ITEMS = 750;
   localparam int CYCLE_LIMIT = 200000;

   // action codes the block leaves undefined
   localparam logic [2:0] ACT_SPARE_6 = 3'd6;
   localparam logic [2:0] ACT_SPARE_7 = 3'd7;

   typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   int error_count, open_count, checked_count;
   int badpos_count, popempty_count, full_count;
   int sent_count  = 0;
   int cycle_count = 0;

   always #5 clock = ~clock;

   positional_deque #(.DEPTH(DEPTH)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   positional_deque_checker #(.DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .error_count    (error_count),
      .open_count     (open_count),
      .checked_count  (checked_count),
      .badpos_count   (badpos_count),
      .popempty_count (popempty_count),
      .full_count     (full_count)
   );

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, open_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic req_type mk(input logic [2:0] act, input logic [31:0] val,
                                  input logic [3:0] pos);
      req_type rq;
      rq.action     = act;
      rq.item_value = val;
      rq.position   = pos;
      return rq;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // one request transfer: optional idle gap, then hold start until taken
   task automatic issue(input req_type rq, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (busy);
      sent_count++;
   endtask

   // hold off until every response has come back
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   initial begin
      req_type   rq;
      phase_type phase;
      int        cut [7];
      int        roll, k, len, n, directed, phase_no;
      bit        burst;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases, starting from the empty store
      issue(mk(ACT_POP_FRONT,  32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_POP_BACK,   32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_ERASE,      32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_INSERT,     32'd5,          4'd3),  pick_gap());
      issue(mk(ACT_SPARE_6,    32'hFFFF_FFFF,  4'd15), pick_gap());
      issue(mk(ACT_INSERT,     32'h7FFF_FFFF,  4'd0),  pick_gap());
      issue(mk(ACT_PUSH_BACK,  32'h8000_0000,  4'd0),  pick_gap());
      issue(mk(ACT_PUSH_FRONT, 32'hFFFF_FFFF,  4'd0),  pick_gap());
      issue(mk(ACT_INSERT,     32'd0,          4'd1),  pick_gap());
      issue(mk(ACT_INSERT,     32'd9,          4'd4),  pick_gap());
      issue(mk(ACT_INSERT,     32'h5555_5555,  4'd3),  pick_gap());
      issue(mk(ACT_ERASE,      32'd0,          4'd15), pick_gap());
      issue(mk(ACT_ERASE,      32'd0,          4'd4),  pick_gap());
      issue(mk(ACT_ERASE,      32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_SPARE_7,    32'h1234_5678,  4'd7),  pick_gap());
      issue(mk(ACT_POP_FRONT,  32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_POP_BACK,   32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_ERASE,      32'd0,          4'd0),  pick_gap());
      issue(mk(ACT_PUSH_BACK,  32'hAAAA_AAAA,  4'd0),  pick_gap());
      directed = sent_count;

      // random phases; cut[] holds cumulative weights in action-code order,
      // the last slot standing for the unused codes
      n        = 0;
      phase_no = 0;
      while (n < RANDOM_ITEMS) begin
         if (phase_no == 0) phase = PH_FILL;
         else if (phase_no == 1) phase = PH_DRAIN;
         else phase = phase_type'($urandom_range(0, 2));
         case (phase)
            PH_FILL:  cut = '{25, 55, 59, 63, 88, 96, 100};
            PH_DRAIN: cut = '{10, 20, 40, 60, 70, 95, 100};
            default:  cut = '{16, 32, 48, 64, 80, 96, 100};
         endcase
         len   = $urandom_range(40, 120);
         if (len > RANDOM_ITEMS - n) len = RANDOM_ITEMS - n;
         burst = ($urandom_range(0, 3) == 0);
         repeat (len) begin
            roll = $urandom_range(0, 99);
            for (k = 0; k < 6 && roll >= cut[k]; k++) ;
            rq.action = (k == 6) ? 3'($urandom_range(6, 7)) : 3'(k);
            if ($urandom_range(0, 9) == 0) begin
               case ($urandom_range(0, 3))
                  0:       rq.item_value = 32'sh8000_0000;
                  1:       rq.item_value = 32'sh7FFF_FFFF;
                  2:       rq.item_value = 32'sh0;
                  default: rq.item_value = -32'sd1;
               endcase
            end else begin
               rq.item_value = $urandom;
            end
            rq.position = $urandom_range(0, 1) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(0, 4));
            issue(rq, burst ? 0 : pick_gap());
            n++;
         end
         // let the pipeline empty between some phases, always after the first
         if (phase_no == 0 || $urandom_range(0, 3) == 0)
            drain();
         phase_no++;
      end

      drain();
      repeat (8) @(posedge clock);

      $display("%0d requests sent (%0d directed) over %0d random phases, %0d responses checked",
               sent_count, directed, phase_no, checked_count);
      $display("bad position %0d, pop on empty %0d, full refused %0d",
               badpos_count, popempty_count, full_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", error_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/pdq_pkg.sv
rtl/core/pdq_ctrl.sv
rtl/core/pdq_cells.sv
rtl/core/positional_deque.sv
verif/positional_deque_checker.sv
verif/positional_deque_tb.sv
